// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the odometry RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ODO_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("odometry assertion failed");

// Property checked on every clock edge, reset included.
`define ODO_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("odometry assertion failed");

`endif

// ===== hdl/odo_pkg.sv =====
// Shared constants, command/status types and the arctangent table of the odometry block.
// No dependencies.
package odo_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 32;
  localparam int TRIG_BITS_DEF  = 16;

  localparam logic [23:0] DIST_PER_TICK_RST  = 24'd96630;
  localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd121363;
  localparam logic [15:0] WRAP_MODULUS_RST   = 16'd9000;

  localparam logic [1:0] REG_DIST_PER_TICK  = 2'd0;
  localparam logic [1:0] REG_INV_WHEEL_BASE = 2'd1;
  localparam logic [1:0] REG_WRAP_MODULUS   = 2'd2;

  localparam logic [29:0] ANGLE_PER_RAD = 30'd683565276;
  localparam logic [29:0] CORDIC_GAIN   = 30'd652032874;

  // Product of the wheel difference and the per-tick angle is kept modulo 2^57.
  localparam int PW = 57;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic rot_mid;
    logic mul_x;
    logic mul_y;
    logic acc;
    logic rot_half;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rot_busy;
  } stat_t;

  function automatic logic [31:0] atan_ba(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/odo_cordic.sv =====
// Iterative CORDIC unit giving sine and cosine of a 32-bit binary angle.
// Depends on odo_pkg for the gain and the arctangent table.
module odo_cordic #(
  parameter int TRIG_BITS = odo_pkg::TRIG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                angle,
  output logic                       busy,
  output logic signed [TRIG_BITS+2:0] sin_val,
  output logic signed [TRIG_BITS+2:0] cos_val
);

  localparam int IW = $clog2(TRIG_BITS);
  localparam int R  = 31 - TRIG_BITS;
  localparam int TW = TRIG_BITS + 3;
  localparam logic signed [33:0] RND = 34'sd1 <<< (R - 1);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [IW-1:0]      cnt;
  logic               flip;
  logic               flip_next;
  logic [31:0]        ang_adj;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  always_comb begin
    flip_next = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    ang_adj   = flip_next ? angle - 32'h80000000 : angle;
    xs        = x >>> cnt;
    ys        = y >>> cnt;
    at        = $signed({2'b00, odo_pkg::atan_ba(5'(cnt))});
    xr        = (x + RND) >>> R;
    yr        = (y + RND) >>> R;
    cos_val   = flip ? -TW'(xr) : TW'(xr);
    sin_val   = flip ? -TW'(yr) : TW'(yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == IW'(TRIG_BITS - 1))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= $signed({4'b0000, odo_pkg::CORDIC_GAIN});
      y    <= '0;
      z    <= 34'($signed(ang_adj));
      cnt  <= '0;
      flip <= flip_next;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== hdl/odo_datapath.sv =====
// Datapath of the odometry block: registers, wrap correction, multipliers and accumulators.
// Depends on odo_pkg and instantiates odo_cordic.
module odo_datapath #(
  parameter int COUNT_BITS = odo_pkg::COUNT_BITS_DEF,
  parameter int POS_BITS   = odo_pkg::POS_BITS_DEF,
  parameter int TRIG_BITS  = odo_pkg::TRIG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  odo_pkg::cmd_t       cmd,
  output odo_pkg::stat_t      status,
  input  logic [15:0]         left_count,
  input  logic [15:0]         right_count,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic [31:0]         heading,
  output logic signed [15:0]  quat_z,
  output logic signed [15:0]  quat_w
);

  localparam int CW   = COUNT_BITS;
  localparam int DW   = ((CW > 16) ? CW : 16) + 2;
  localparam int SUMW = DW + 1;
  localparam int RW   = SUMW + 25;
  localparam int CMPW = (RW > 42) ? RW : 42;
  localparam int DCW  = 41;
  localparam int TW   = TRIG_BITS + 3;
  localparam int TF   = TRIG_BITS - 1;
  localparam int PRW  = DCW + TW;
  localparam int SW   = ((POS_BITS > PRW) ? POS_BITS : PRW) + 1;
  localparam int PW   = odo_pkg::PW;
  localparam int RSH  = (TF > 15) ? TF - 15 : 0;
  localparam int LSH  = (TF < 15) ? 15 - TF : 0;
  localparam int QW   = TW + 16;

  localparam logic signed [CMPW-1:0] DC_MAX = {{(CMPW-40){1'b0}}, 1'b1, 39'b0};
  localparam logic signed [CMPW-1:0] DC_MIN = -DC_MAX;
  localparam logic signed [PRW-1:0]  HALF   = PRW'(1) <<< (TF - 1);
  localparam logic signed [SW-1:0]   POS_HI = (SW'(1) <<< (POS_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0]   POS_LO = -POS_HI - SW'(1);
  localparam logic signed [QW-1:0]   QRND   = (RSH > 0) ? (QW'(1) <<< (RSH - 1)) : '0;

  function automatic logic signed [DW-1:0] wrap_delta(input logic [CW-1:0] cur,
                                                      input logic [CW-1:0] prev,
                                                      input logic [15:0]   m);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] mm;
    logic signed [DW-1:0] hh;
    d  = $signed(DW'(cur)) - $signed(DW'(prev));
    mm = $signed(DW'(m));
    hh = $signed(DW'(m >> 1));
    if (d > hh) d = d - mm;
    if (d < -hh) d = d + mm;
    return d;
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_add(input logic signed [POS_BITS-1:0] a,
                                                        input logic signed [PRW-1:0] pr);
    logic signed [PRW-1:0] dd;
    logic signed [SW-1:0]  s;
    dd = (pr + HALF) >>> TF;
    s  = SW'(a) + SW'(dd);
    if (s > POS_HI) s = POS_HI;
    if (s < POS_LO) s = POS_LO;
    return POS_BITS'(s);
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [TW-1:0] v);
    logic signed [QW-1:0] t;
    t = ((QW'(v) <<< LSH) + QRND) >>> RSH;
    if (t > QW'(32767)) t = QW'(32767);
    if (t < -QW'(32768)) t = -QW'(32768);
    return 16'(t);
  endfunction

  logic [23:0]                dist_per_tick;
  logic [23:0]                inv_wheel_base;
  logic [15:0]                wrap_modulus;
  logic [CW-1:0]              last_left;
  logic [CW-1:0]              last_right;
  logic signed [POS_BITS-1:0] acc_x;
  logic signed [POS_BITS-1:0] acc_y;
  logic [31:0]                acc_heading;

  logic signed [DW-1:0]   dl;
  logic signed [DW-1:0]   dr;
  logic [31:0]            rate;
  logic [PW-1:0]          pt;
  logic signed [RW-1:0]   dc_raw;
  logic [PW-1:0]          plo;
  logic [PW-1:0]          p;
  logic signed [DCW-1:0]  dc;
  logic signed [PRW-1:0]  prod;

  logic [CW-1:0]           cur_l;
  logic [CW-1:0]           cur_r;
  logic signed [SUMW-1:0]  dsum;
  logic signed [SUMW-1:0]  ddiff;
  logic [47:0]             rate_full;
  logic [61:0]             pt_full;
  logic signed [RW-1:0]    mul_dc;
  logic signed [RW-1:0]    dc_sh;
  logic signed [CMPW-1:0]  dc_cmp;
  logic signed [SUMW+29:0] mlo;
  logic signed [SUMW+28:0] mhi;
  logic [31:0]             mid;
  logic [31:0]             rot_angle;
  logic signed [TW-1:0]    sin_val;
  logic signed [TW-1:0]    cos_val;

  always_comb begin
    cur_l     = CW'(left_count);
    cur_r     = CW'(right_count);
    dsum      = SUMW'(dl) + SUMW'(dr);
    ddiff     = SUMW'(dr) - SUMW'(dl);
    rate_full = 48'(dist_per_tick) * 48'(inv_wheel_base);
    pt_full   = 62'(rate) * 62'(odo_pkg::ANGLE_PER_RAD);
    mul_dc    = dsum * $signed({1'b0, dist_per_tick});
    dc_sh     = dc_raw >>> 9;
    dc_cmp    = CMPW'(dc_sh);
    mlo       = ddiff * $signed({1'b0, pt[28:0]});
    mhi       = ddiff * $signed({1'b0, pt[56:29]});
    mid       = acc_heading + p[56:25];
    rot_angle = cmd.rot_mid ? mid : {1'b0, acc_heading[31:1]};
  end

  odo_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.rot_mid | cmd.rot_half),
    .angle   (rot_angle),
    .busy    (status.rot_busy),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_tick  <= odo_pkg::DIST_PER_TICK_RST;
      inv_wheel_base <= odo_pkg::INV_WHEEL_BASE_RST;
      wrap_modulus   <= odo_pkg::WRAP_MODULUS_RST;
      last_left      <= '0;
      last_right     <= '0;
      acc_x          <= '0;
      acc_y          <= '0;
      acc_heading    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          odo_pkg::REG_DIST_PER_TICK:  dist_per_tick  <= cfg_data;
          odo_pkg::REG_INV_WHEEL_BASE: inv_wheel_base <= cfg_data;
          odo_pkg::REG_WRAP_MODULUS:   wrap_modulus   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        last_left  <= cur_l;
        last_right <= cur_r;
      end
      if (cmd.mul_y) begin
        acc_x <= sat_add(acc_x, prod);
      end
      if (cmd.acc) begin
        acc_y       <= sat_add(acc_y, prod);
        acc_heading <= acc_heading + p[55:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dl   <= wrap_delta(cur_l, last_left, wrap_modulus);
      dr   <= wrap_delta(cur_r, last_right, wrap_modulus);
      rate <= rate_full[47:16];
    end
    if (cmd.mul1) begin
      pt     <= pt_full[PW-1:0];
      dc_raw <= mul_dc;
    end
    if (cmd.mul2) begin
      plo <= PW'(mlo);
      if (dc_cmp > DC_MAX) begin
        dc <= DCW'(DC_MAX);
      end else if (dc_cmp < DC_MIN) begin
        dc <= DCW'(DC_MIN);
      end else begin
        dc <= DCW'(dc_cmp);
      end
    end
    if (cmd.mul3) begin
      p <= plo + (PW'(mhi) << 29);
    end
    if (cmd.mul_x) begin
      prod <= dc * cos_val;
    end
    if (cmd.mul_y) begin
      prod <= dc * sin_val;
    end
    if (cmd.out_load) begin
      pos_x   <= 32'(acc_x);
      pos_y   <= 32'(acc_y);
      heading <= acc_heading;
      quat_z  <= to_q15(sin_val);
      quat_w  <= to_q15(cos_val);
    end
  end

endmodule

// ===== hdl/odo_ctrl.sv =====
// Controller state machine of the odometry block, sequencing the datapath per request.
// Depends on odo_pkg for the command and status types.
module odo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output odo_pkg::cmd_t  cmd,
  input  odo_pkg::stat_t status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_MUL2   = 4'd2;
  localparam logic [3:0] S_MUL3   = 4'd3;
  localparam logic [3:0] S_START1 = 4'd4;
  localparam logic [3:0] S_WAIT1  = 4'd5;
  localparam logic [3:0] S_MULX   = 4'd6;
  localparam logic [3:0] S_MULY   = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_START2 = 4'd9;
  localparam logic [3:0] S_WAIT2  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_START1;
      end
      S_START1: begin
        cmd.rot_mid = 1'b1;
        state_next  = S_WAIT1;
      end
      S_WAIT1: begin
        if (!status.rot_busy) state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_START2;
      end
      S_START2: begin
        cmd.rot_half = 1'b1;
        state_next   = S_WAIT2;
      end
      S_WAIT2: begin
        if (!status.rot_busy) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/diff_drive_encoder_odometry.sv =====
// Differential-drive wheel odometry: one pose result per request of raw encoder counts.
// A request runs from acceptance to result through the two passes of the single iterative
// CORDIC unit, one rotation per cycle; one request is worked at a time, a new one can be
// taken in the same cycle as the result appears, and the next is taken while the last result
// waits.
// Depends on odo_pkg, odo_ctrl, odo_datapath and assert_macros.svh.
`include "assert_macros.svh"

module diff_drive_encoder_odometry #(
  parameter int COUNT_BITS = odo_pkg::COUNT_BITS_DEF,
  parameter int POS_BITS   = odo_pkg::POS_BITS_DEF,
  parameter int TRIG_BITS  = odo_pkg::TRIG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        left_count,
  input  logic [15:0]        right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  odo_pkg::cmd_t  cmd;
  odo_pkg::stat_t status;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  odo_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .POS_BITS   (POS_BITS),
    .TRIG_BITS  (TRIG_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .left_count  (left_count),
    .right_count (right_count),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .quat_z      (quat_z),
    .quat_w      (quat_w)
  );

  `ODO_ASSERT(a_accept_closes, (in_valid && in_ready) |=> !in_ready)
  `ODO_ASSERT(a_idle_not_rotating, in_ready |-> !status.rot_busy)
  `ODO_ASSERT(a_rotation_starts, (cmd.rot_mid || cmd.rot_half) |=> status.rot_busy)
  `ODO_ASSERT(a_result_shown, cmd.out_load |=> out_valid)

endmodule
